/* src/mfc_pkg.sv */
// ----------------------------------------------------------------------------
// mfc_pkg
// Shared types and constants for the clipped-window streaming median filter.
// ----------------------------------------------------------------------------
package mfc_pkg;

   localparam int MFC_MAX_RADIUS = 2;
   localparam int MFC_MAX_WIDTH  = 2048;
   localparam int MFC_MAX_HEIGHT = 4096;

   localparam int PIX_W = 16;
   localparam int MED_W = 17;

   localparam int CFG_WIDTH_W  = 12;
   localparam int CFG_HEIGHT_W = 13;
   localparam int CFG_RADIUS_W = 2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CFG_WIDTH_W-1:0]  CFG_WIDTH_RESET  = 12'd2048;
   localparam logic [CFG_HEIGHT_W-1:0] CFG_HEIGHT_RESET = 13'd2048;
   localparam logic [CFG_RADIUS_W-1:0] CFG_RADIUS_RESET = 2'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_IMAGE_WIDTH   = 2'd0,
      REG_IMAGE_HEIGHT  = 2'd1,
      REG_WINDOW_RADIUS = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } operation_type;

   typedef struct packed {
      logic launch;
      logic frame_end;
   } mfc_ctrl_type;

endpackage

/* src/mfc_req_if.sv */
// ----------------------------------------------------------------------------
// mfc_req_if
// Input channel: pixel or drain word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mfc_req_if;
   import mfc_pkg::*;

   logic                 valid;
   logic                 ready;
   operation_type        operation;
   logic [PIX_W-1:0]     pixel_value;

   modport source (output valid, output operation, output pixel_value, input ready);
   modport sink   (input valid, input operation, input pixel_value, output ready);
endinterface

/* src/mfc_rsp_if.sv */
// ----------------------------------------------------------------------------
// mfc_rsp_if
// Result channel: filtered pixel word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mfc_rsp_if;
   import mfc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [MED_W-1:0]     median_twice;
   logic                 frame_end;

   modport source (output valid, output median_twice, output frame_end, input ready);
   modport sink   (input valid, input median_twice, input frame_end, output ready);
endinterface

/* src/mfc_line_store.sv */
// ----------------------------------------------------------------------------
// mfc_line_store
// Column-organized line buffer: one word per image column holding one pixel
// per ring row, lane write, registered column read with write forwarding.
// ----------------------------------------------------------------------------
module mfc_line_store #(
   parameter int MAX_WIDTH = mfc_pkg::MFC_MAX_WIDTH,
   parameter int RING      = 3 * mfc_pkg::MFC_MAX_RADIUS + 1,
   localparam int AW       = $clog2(MAX_WIDTH),
   localparam int LW       = $clog2(RING)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic [AW-1:0]                      wr_addr,
   input  logic [LW-1:0]                      wr_lane,
   input  logic [mfc_pkg::PIX_W-1:0]          wr_data,
   input  logic                               rd_en,
   input  logic [AW-1:0]                      rd_addr,
   output logic [RING*mfc_pkg::PIX_W-1:0]     rd_data
);
   import mfc_pkg::*;

   logic [RING*PIX_W-1:0] mem [MAX_WIDTH];
   logic [RING*PIX_W-1:0] rd_ff;
   logic                  hit_ff;
   logic [LW-1:0]         hit_lane_ff;
   logic [PIX_W-1:0]      hit_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr][wr_lane*PIX_W +: PIX_W] <= wr_data;
      end
      if (rd_en) begin
         rd_ff       <= mem[rd_addr];
         hit_lane_ff <= wr_lane;
         hit_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (rd_en) begin
         hit_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   // patch the lane written in the read cycle
   always_comb begin
      for (int l = 0; l < RING; l++) begin
         if (hit_ff && (hit_lane_ff == LW'(l))) begin
            rd_data[l*PIX_W +: PIX_W] = hit_data_ff;
         end else begin
            rd_data[l*PIX_W +: PIX_W] = rd_ff[l*PIX_W +: PIX_W];
         end
      end
   end

   a_fwd_source: assert property (@(posedge clock) disable iff (reset)
      $rose(hit_ff) |-> $past(wr_en && rd_en && (wr_addr == rd_addr)))
      else $error("forwarding hit without matching write");

endmodule

/* src/mfc_median.sv */
// ----------------------------------------------------------------------------
// mfc_median
// Rank-selection median over the masked window: compare matrix, rank sums,
// then middle-pair select and add into the output register.
// ----------------------------------------------------------------------------
module mfc_median #(
   parameter int MAX_RADIUS = mfc_pkg::MFC_MAX_RADIUS,
   localparam int NWIN      = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  mfc_pkg::mfc_ctrl_type                 ctrl,
   input  logic [NWIN-1:0][mfc_pkg::PIX_W-1:0]   win_data,
   input  logic [NWIN-1:0]                       win_vld,
   output logic                                  rsp_valid,
   output logic [mfc_pkg::MED_W-1:0]             rsp_median,
   output logic                                  rsp_frame_end
);
   import mfc_pkg::*;

   localparam int RKW = $clog2(NWIN + 1);

   logic [NWIN-1:0]    lt_in [NWIN];
   logic [RKW-1:0]     n_in;

   logic               m1_vld_ff, m1_fend_ff;
   logic [NWIN-1:0]    m1_lt_ff [NWIN];
   logic [PIX_W-1:0]   m1_data_ff [NWIN];
   logic [RKW-1:0]     m1_n_ff;

   logic [RKW-1:0]     rank_in [NWIN];
   logic               m2_vld_ff, m2_fend_ff, m2_zero_ff;
   logic [RKW-1:0]     m2_rank_ff [NWIN];
   logic [PIX_W-1:0]   m2_data_ff [NWIN];
   logic [RKW-1:0]     m2_klo_ff, m2_khi_ff;

   logic [PIX_W-1:0]   lo_sel, hi_sel;
   logic               rsp_valid_ff, rsp_fend_ff;
   logic [MED_W-1:0]   rsp_median_ff;

   // invalid entries sort above every pixel; ties break by position
   always_comb begin
      logic [PIX_W:0] key [NWIN];
      for (int i = 0; i < NWIN; i++) begin
         key[i] = {~win_vld[i], win_data[i]};
      end
      for (int i = 0; i < NWIN; i++) begin
         for (int j = 0; j < NWIN; j++) begin
            lt_in[i][j] = (key[i] < key[j]) || ((key[i] == key[j]) && (i < j));
         end
      end
      n_in = '0;
      for (int i = 0; i < NWIN; i++) begin
         n_in = n_in + RKW'(win_vld[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < NWIN; i++) begin
         rank_in[i] = '0;
         for (int j = 0; j < NWIN; j++) begin
            rank_in[i] = rank_in[i] + RKW'(m1_lt_ff[j][i]);
         end
      end
   end

   always_comb begin
      lo_sel = '0;
      hi_sel = '0;
      for (int i = 0; i < NWIN; i++) begin
         if (m2_rank_ff[i] == m2_klo_ff) begin
            lo_sel = lo_sel | m2_data_ff[i];
         end
         if (m2_rank_ff[i] == m2_khi_ff) begin
            hi_sel = hi_sel | m2_data_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_fend_ff <= ctrl.frame_end;
         m1_n_ff    <= n_in;
         for (int i = 0; i < NWIN; i++) begin
            m1_lt_ff[i]   <= lt_in[i];
            m1_data_ff[i] <= win_data[i];
         end
         m2_fend_ff <= m1_fend_ff;
         m2_zero_ff <= (m1_n_ff == '0);
         m2_klo_ff  <= (m1_n_ff - RKW'(1)) >> 1;
         m2_khi_ff  <= m1_n_ff >> 1;
         for (int i = 0; i < NWIN; i++) begin
            m2_rank_ff[i] <= rank_in[i];
            m2_data_ff[i] <= m1_data_ff[i];
         end
         rsp_fend_ff   <= m2_fend_ff;
         rsp_median_ff <= m2_zero_ff ? '0 : (MED_W'(lo_sel) + MED_W'(hi_sel));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff    <= 1'b0;
         m2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         m1_vld_ff    <= ctrl.launch;
         m2_vld_ff    <= m1_vld_ff;
         rsp_valid_ff <= m2_vld_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_median    = rsp_median_ff;
   assign rsp_frame_end = rsp_fend_ff;

endmodule

/* src/median_filter_clipped_top.sv */
// ----------------------------------------------------------------------------
// median_filter_clipped_top
// Streaming 2-D median filter with a border-clipped square window.
// ----------------------------------------------------------------------------
// Accepts one word per clock while the output is not stalled and no row-start
// column load is under way, and returns twice the window median of each pixel
// in raster order, as soon as its clipped window has arrived. The line store
// holds one column word per image column and is read one column per cycle, so
// an output that starts a new image row first loads its first columns with the
// input held off. The line store needs no clearing pass after reset.
module median_filter_clipped_top #(
   parameter int MAX_RADIUS = mfc_pkg::MFC_MAX_RADIUS,
   parameter int MAX_WIDTH  = mfc_pkg::MFC_MAX_WIDTH,
   parameter int MAX_HEIGHT = mfc_pkg::MFC_MAX_HEIGHT
) (
   input  logic                              clock,
   input  logic                              reset,
   mfc_req_if.sink                           req_ch,
   mfc_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [mfc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mfc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import mfc_pkg::*;

   localparam int SIDE = 2 * MAX_RADIUS + 1;
   localparam int NWIN = SIDE * SIDE;
   localparam int RING = 3 * MAX_RADIUS + 1;
   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int RW   = $clog2(MAX_HEIGHT);
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int HW   = $clog2(MAX_HEIGHT + 1);
   localparam int RDW  = $clog2(MAX_RADIUS + 1);
   localparam int LW   = $clog2(RING);
   localparam int XW   = $clog2(MAX_WIDTH + MAX_RADIUS);
   localparam int DW   = $clog2(MAX_RADIUS * (MAX_WIDTH + 1) + 2);

   logic [CFG_WIDTH_W-1:0]  cfg_w_ff;
   logic [CFG_HEIGHT_W-1:0] cfg_h_ff;
   logic [CFG_RADIUS_W-1:0] cfg_r_ff;
   logic [WW-1:0]           eff_w;
   logic [HW-1:0]           eff_h;
   logic [RDW-1:0]          eff_r;
   logic [DW-1:0]           lat;

   logic [CW-1:0]  in_col_ff, out_col_ff;
   logic [RW-1:0]  in_row_ff, out_row_ff;
   logic [LW-1:0]  in_ring_ff, out_ring_ff;
   logic [DW-1:0]  diff_ff, diff_new;
   logic           in_done_ff, in_done_in;

   logic           adv, fire, wr_en, emit, row_start, fetching, issue;
   logic           in_col_end, in_row_end, out_col_end, out_row_end, out_last;

   logic [RDW-1:0] fetch_cnt_ff, fetch_col_ff;
   logic [RW-1:0]  ctx_row_ff;
   logic [LW-1:0]  ctx_ring_ff;
   logic           ctx_fend_ff;

   logic [XW-1:0]  s0_x;
   logic           s0_launch, s0_clear, s0_fend, s0_colv;
   logic [RW-1:0]  s0_row;
   logic [LW-1:0]  s0_ring;
   logic [SIDE-1:0] s0_rowv;

   logic           s1_vld_ff, s1_launch_ff, s1_clear_ff, s1_fend_ff, s1_colv_ff;
   logic [SIDE-1:0] s1_rowv_ff;
   logic [LW-1:0]  s1_ring_ff;

   logic [RING*PIX_W-1:0] st_rd_data;
   logic [PIX_W-1:0]      col_data [SIDE];
   logic [SIDE-1:0]       col_vld;

   logic [PIX_W-1:0]      win_ff [NWIN];
   logic [NWIN-1:0]       win_vld_ff;
   logic [NWIN-1:0][PIX_W-1:0] med_data;
   logic [NWIN-1:0]       med_vld;

   mfc_ctrl_type          med_ctrl;
   logic                  s2_launch_ff, s2_fend_ff;
   logic                  med_valid;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff <= CFG_WIDTH_RESET;
         cfg_h_ff <= CFG_HEIGHT_RESET;
         cfg_r_ff <= CFG_RADIUS_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            REG_IMAGE_WIDTH:   cfg_w_ff <= csr_wdata[CFG_WIDTH_W-1:0];
            REG_IMAGE_HEIGHT:  cfg_h_ff <= csr_wdata[CFG_HEIGHT_W-1:0];
            REG_WINDOW_RADIUS: cfg_r_ff <= csr_wdata[CFG_RADIUS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (cfg_w_ff == '0) begin
         eff_w = WW'(1);
      end else if (32'(cfg_w_ff) > MAX_WIDTH) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(cfg_w_ff);
      end
      if (cfg_h_ff == '0) begin
         eff_h = HW'(1);
      end else if (32'(cfg_h_ff) > MAX_HEIGHT) begin
         eff_h = HW'(MAX_HEIGHT);
      end else begin
         eff_h = HW'(cfg_h_ff);
      end
      if (32'(cfg_r_ff) > MAX_RADIUS) begin
         eff_r = RDW'(MAX_RADIUS);
      end else begin
         eff_r = RDW'(cfg_r_ff);
      end
      lat = DW'(32'(eff_r) * 32'(eff_w) + 32'(eff_r));
   end

   // accept and release decisions
   assign adv          = !med_valid || rsp_ch.ready;
   assign req_ch.ready = adv && (fetch_cnt_ff == '0);
   assign fire         = req_ch.valid && req_ch.ready;
   assign wr_en        = fire && (req_ch.operation == OP_PIXEL) && !in_done_ff;

   assign in_col_end  = (WW'(in_col_ff) == eff_w - WW'(1));
   assign in_row_end  = (HW'(in_row_ff) == eff_h - HW'(1));
   assign out_col_end = (WW'(out_col_ff) == eff_w - WW'(1));
   assign out_row_end = (HW'(out_row_ff) == eff_h - HW'(1));
   assign out_last    = out_col_end && out_row_end;

   assign in_done_in  = in_done_ff || (wr_en && in_col_end && in_row_end);
   assign diff_new    = diff_ff + DW'(wr_en);
   assign emit        = fire && (in_done_in || (diff_new > lat));
   assign row_start   = (out_col_ff == '0) && (eff_r != '0);
   assign fetching    = adv && (fetch_cnt_ff != '0);
   assign issue       = emit || fetching;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_ring_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_ring_ff <= '0;
         diff_ff     <= '0;
         in_done_ff  <= 1'b0;
      end else if (emit && out_last) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_ring_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_ring_ff <= '0;
         diff_ff     <= '0;
         in_done_ff  <= 1'b0;
      end else begin
         in_done_ff <= in_done_in;
         diff_ff    <= diff_new - DW'(emit);
         if (wr_en) begin
            if (in_col_end) begin
               in_col_ff  <= '0;
               in_row_ff  <= in_row_ff + RW'(1);
               in_ring_ff <= (in_ring_ff == LW'(RING - 1)) ? '0 : in_ring_ff + LW'(1);
            end else begin
               in_col_ff <= in_col_ff + CW'(1);
            end
         end
         if (emit) begin
            if (out_col_end) begin
               out_col_ff  <= '0;
               out_row_ff  <= out_row_ff + RW'(1);
               out_ring_ff <= (out_ring_ff == LW'(RING - 1)) ? '0 : out_ring_ff + LW'(1);
            end else begin
               out_col_ff <= out_col_ff + CW'(1);
            end
         end
      end
   end

   // row-start column loader
   always_ff @(posedge clock) begin
      if (reset) begin
         fetch_cnt_ff <= '0;
      end else if (emit && row_start) begin
         fetch_cnt_ff <= eff_r;
      end else if (fetching) begin
         fetch_cnt_ff <= fetch_cnt_ff - RDW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (emit && row_start) begin
         fetch_col_ff <= RDW'(1);
         ctx_row_ff   <= out_row_ff;
         ctx_ring_ff  <= out_ring_ff;
         ctx_fend_ff  <= out_last;
      end else if (fetching) begin
         fetch_col_ff <= fetch_col_ff + RDW'(1);
      end
   end

   // column read request
   always_comb begin
      int rr;
      if (emit) begin
         s0_x      = row_start ? '0 : XW'(out_col_ff) + XW'(eff_r);
         s0_launch = !row_start;
         s0_clear  = (out_col_ff == '0);
         s0_fend   = out_last;
         s0_row    = out_row_ff;
         s0_ring   = out_ring_ff;
      end else begin
         s0_x      = XW'(fetch_col_ff);
         s0_launch = (fetch_cnt_ff == RDW'(1));
         s0_clear  = 1'b0;
         s0_fend   = ctx_fend_ff;
         s0_row    = ctx_row_ff;
         s0_ring   = ctx_ring_ff;
      end
      s0_colv = (32'(s0_x) < 32'(eff_w));
      for (int d = 0; d < SIDE; d++) begin
         rr = int'(s0_row) + d - MAX_RADIUS;
         s0_rowv[d] = (d >= MAX_RADIUS - int'(eff_r)) && (d <= MAX_RADIUS + int'(eff_r))
                   && (rr >= 0) && (rr < int'(eff_h));
      end
   end

   mfc_line_store #(
      .MAX_WIDTH (MAX_WIDTH),
      .RING      (RING)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (in_col_ff),
      .wr_lane (in_ring_ff),
      .wr_data (req_ch.pixel_value),
      .rd_en   (issue && s0_colv),
      .rd_addr (s0_x[CW-1:0]),
      .rd_data (st_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_launch_ff <= s0_launch;
         s1_clear_ff  <= s0_clear;
         s1_fend_ff   <= s0_fend;
         s1_colv_ff   <= s0_colv;
         s1_rowv_ff   <= s0_rowv;
         s1_ring_ff   <= s0_ring;
      end
   end

   // map ring lanes onto window rows
   always_comb begin
      int t;
      for (int d = 0; d < SIDE; d++) begin
         t = int'(s1_ring_ff) + RING + d - MAX_RADIUS;
         if (t >= RING) t = t - RING;
         if (t >= RING) t = t - RING;
         col_data[d] = st_rd_data[t*PIX_W +: PIX_W];
         col_vld[d]  = s1_colv_ff && s1_rowv_ff[d];
      end
   end

   // window shift line
   always_ff @(posedge clock) begin
      if (adv && s1_vld_ff) begin
         for (int s = 0; s < SIDE - 1; s++) begin
            for (int d = 0; d < SIDE; d++) begin
               win_ff[s*SIDE + d] <= win_ff[(s+1)*SIDE + d];
            end
         end
         for (int d = 0; d < SIDE; d++) begin
            win_ff[(SIDE-1)*SIDE + d] <= col_data[d];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_vld_ff   <= '0;
         s2_launch_ff <= 1'b0;
      end else if (adv) begin
         s2_launch_ff <= s1_vld_ff && s1_launch_ff;
         if (s1_vld_ff) begin
            for (int s = 0; s < SIDE - 1; s++) begin
               for (int d = 0; d < SIDE; d++) begin
                  win_vld_ff[s*SIDE + d] <= win_vld_ff[(s+1)*SIDE + d] && !s1_clear_ff;
               end
            end
            for (int d = 0; d < SIDE; d++) begin
               win_vld_ff[(SIDE-1)*SIDE + d] <= col_vld[d];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_fend_ff <= s1_fend_ff;
      end
   end

   always_comb begin
      for (int s = 0; s < SIDE; s++) begin
         for (int d = 0; d < SIDE; d++) begin
            med_data[s*SIDE + d] = win_ff[s*SIDE + d];
            med_vld[s*SIDE + d]  = win_vld_ff[s*SIDE + d]
                                && (s >= SIDE - 1 - 2 * int'(eff_r));
         end
      end
      med_ctrl.launch    = s2_launch_ff;
      med_ctrl.frame_end = s2_fend_ff;
   end

   mfc_median #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_median (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .ctrl          (med_ctrl),
      .win_data      (med_data),
      .win_vld       (med_vld),
      .rsp_valid     (med_valid),
      .rsp_median    (rsp_ch.median_twice),
      .rsp_frame_end (rsp_ch.frame_end)
   );

   assign rsp_ch.valid = med_valid;

   a_no_emit_in_fetch: assert property (@(posedge clock) disable iff (reset)
      (fetch_cnt_ff != '0) |-> !emit)
      else $error("release overlaps row-start column load");

   a_done_by_write: assert property (@(posedge clock) disable iff (reset)
      $rose(in_done_ff) |-> $past(wr_en))
      else $error("frame complete without a written pixel");

   a_done_clear: assert property (@(posedge clock) disable iff (reset)
      $fell(in_done_ff) |-> $past(emit && out_last))
      else $error("frame complete cleared without the final output");

endmodule

/* tb/sv/median_filter_clipped_top_tb.sv */
// ----------------------------------------------------------------------------
// median_filter_clipped_top_tb
// Self-checking bench for the clipped-window streaming median filter.
// ----------------------------------------------------------------------------
// Streams whole frames of pixel words through the filter under several image
// sizes and window radii, followed by drain words that flush the outputs
// still pending. A behavioral line store and sorter predict twice the median
// of every clipped window, together with the frame-end flag. Each result word
// is compared in order against those predictions. Sizes change only between
// frames, once the filter has gone idle. Both sides throttle at random, except in phases that set both rates to zero.
// ----------------------------------------------------------------------------
module median_filter_clipped_top_tb;
   import mfc_pkg::*;

   localparam int RING_ROWS = 3 * MFC_MAX_RADIUS + 1;
   localparam int WIN_MAX   = (2 * MFC_MAX_RADIUS + 1) * (2 * MFC_MAX_RADIUS + 1);
   localparam int QUIET_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 20;

   typedef struct {
      operation_type    op;
      logic [PIX_W-1:0] pix;
   } pixel_word_type;

   typedef struct {
      logic [MED_W-1:0] median_twice;
      logic             frame_end;
   } filtered_word_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   mfc_req_if req_ch ();
   mfc_rsp_if rsp_ch ();

   median_filter_clipped_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pixel_word_type    pending_words[$];
   filtered_word_type expected_medians[$];
   int             fail_count = 0;
   int             quiet_cycles = 0;
   int             send_idle_pct = 35;
   int             recv_stall_pct = 86;

   logic [CFG_WIDTH_W-1:0]  img_width;
   logic [CFG_HEIGHT_W-1:0] img_height;
   logic [CFG_RADIUS_W-1:0] win_radius;
   logic [PIX_W-1:0]        line_mem [0:RING_ROWS*MFC_MAX_WIDTH-1];
   int unsigned             in_col, in_row, out_col, out_row;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic int unsigned eff_width();
      if (img_width < 1) return 1;
      if (img_width > MFC_MAX_WIDTH) return MFC_MAX_WIDTH;
      return 32'(img_width);
   endfunction

   function automatic int unsigned eff_height();
      if (img_height < 1) return 1;
      if (img_height > MFC_MAX_HEIGHT) return MFC_MAX_HEIGHT;
      return 32'(img_height);
   endfunction

   function automatic int unsigned eff_radius();
      return (win_radius > MFC_MAX_RADIUS) ? MFC_MAX_RADIUS : 32'(win_radius);
   endfunction

   function automatic logic [MED_W-1:0] window_median_twice(int unsigned r, int unsigned c);
      logic [PIX_W-1:0] vals [WIN_MAX];
      logic [PIX_W-1:0] v;
      int unsigned w, h, rad, r0, r1, c0, c1, n;
      int j;
      w = eff_width();
      h = eff_height();
      rad = eff_radius();
      n = 0;
      if (c > w - 1) c = w - 1;
      if (r > h - 1) r = h - 1;
      r0 = (r >= rad) ? r - rad : 0;
      c0 = (c >= rad) ? c - rad : 0;
      r1 = (r + rad > h - 1) ? h - 1 : r + rad;
      c1 = (c + rad > w - 1) ? w - 1 : c + rad;
      for (int unsigned y = r0; y <= r1; y++) begin
         for (int unsigned x = c0; x <= c1; x++) begin
            vals[n] = line_mem[(y % RING_ROWS) * MFC_MAX_WIDTH + x];
            n++;
         end
      end
      for (int i = 1; i < n; i++) begin
         v = vals[i];
         j = i;
         while (j > 0 && vals[j-1] > v) begin
            vals[j] = vals[j-1];
            j--;
         end
         vals[j] = v;
      end
      if (n % 2 == 1) return {1'b0, vals[n/2]} << 1;
      return {1'b0, vals[n/2-1]} + {1'b0, vals[n/2]};
   endfunction

   function automatic void clear_positions();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
   endfunction

   function automatic void filter_step(pixel_word_type wd);
      int unsigned w, h, rad, hw, lat, in_lin, out_lin;
      filtered_word_type res;
      w = eff_width();
      h = eff_height();
      rad = eff_radius();
      hw = w * h;
      lat = rad * w + rad;
      in_lin = in_row * w + in_col;
      out_lin = out_row * w + out_col;
      if (wd.op == OP_PIXEL && in_lin < hw) begin
         line_mem[(in_row % RING_ROWS) * MFC_MAX_WIDTH + in_col] = wd.pix;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
         in_lin++;
      end
      if (out_lin >= hw) begin
         if (in_lin >= hw) clear_positions();
         return;
      end
      if (!(in_lin >= hw || in_lin >= out_lin + lat + 1)) return;
      res.median_twice = window_median_twice(out_row, out_col);
      res.frame_end = (out_lin == hw - 1);
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
      end
      if (res.frame_end) clear_positions();
      expected_medians.push_back(res);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.operation <= OP_PIXEL;
         req_ch.pixel_value <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            filter_step('{op: req_ch.operation, pix: req_ch.pixel_value});
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               pixel_word_type nxt;
               nxt = pending_words.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.operation <= nxt.op;
               req_ch.pixel_value <= nxt.pix;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_medians.size() == 0) begin
               $display("%0t: unexpected word median_twice=%0d frame_end=%0b", $time,
                        rsp_ch.median_twice, rsp_ch.frame_end);
               fail_count++;
            end else begin
               filtered_word_type exp_w;
               exp_w = expected_medians.pop_front();
               if (rsp_ch.median_twice !== exp_w.median_twice) begin
                  $display("%0t: median_twice expected %0d actual %0d", $time,
                           exp_w.median_twice, rsp_ch.median_twice);
                  fail_count++;
               end
               if (rsp_ch.frame_end !== exp_w.frame_end) begin
                  $display("%0t: frame_end expected %0b actual %0b", $time,
                           exp_w.frame_end, rsp_ch.frame_end);
                  fail_count++;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL median_filter_clipped_top");
         $finish;
      end
   end

   task automatic wait_idle();
      while (pending_words.size() > 0 || req_ch.valid || expected_medians.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int unsigned value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_IMAGE_WIDTH:   img_width = value[CFG_WIDTH_W-1:0];
         REG_IMAGE_HEIGHT:  img_height = value[CFG_HEIGHT_W-1:0];
         REG_WINDOW_RADIUS: win_radius = value[CFG_RADIUS_W-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [PIX_W-1:0] random_pixel();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // push one frame; returns the number of image pixels in it
   task automatic run_frame(int unsigned w_raw, int unsigned h_raw, int unsigned r_raw,
                            output int unsigned pixels);
      int unsigned hw, lat, pend, tail;
      wait_idle();
      write_reg(REG_IMAGE_WIDTH, w_raw);
      write_reg(REG_IMAGE_HEIGHT, h_raw);
      write_reg(REG_WINDOW_RADIUS, r_raw);
      hw = eff_width() * eff_height();
      lat = eff_radius() * eff_width() + eff_radius();
      pend = (hw - 1 < lat) ? hw - 1 : lat;
      tail = $urandom_range(1, 3);
      pixels = hw;
      for (int unsigned k = 0; k < hw; k++) begin
         if ($urandom_range(0, 19) == 0)
            pending_words.push_back('{op: OP_DRAIN, pix: random_pixel()});
         pending_words.push_back('{op: OP_PIXEL, pix: random_pixel()});
      end
      // surplus pixels before the frame closes act as drains
      for (int unsigned k = 0; k < pend; k++)
         pending_words.push_back('{op: ($urandom_range(0, 4) == 0) ? OP_PIXEL : OP_DRAIN,
                                   pix: random_pixel()});
      for (int unsigned k = 0; k < tail; k++)
         pending_words.push_back('{op: OP_DRAIN, pix: random_pixel()});
   endtask

   initial begin
      int unsigned got, total;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = REG_IMAGE_WIDTH;
      csr_wdata = '0;
      img_width = CFG_WIDTH_RESET;
      img_height = CFG_HEIGHT_RESET;
      win_radius = CFG_RADIUS_RESET;
      clear_positions();
      total = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_frame(4, 3, 1, got);
      total += got;
      run_frame(0, 0, 0, got);
      total += got;
      run_frame(5, 5, 3, got);
      total += got;
      run_frame(2, 7, 2, got);
      total += got;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      run_frame(40, 0, 1, got);
      total += got;
      run_frame(0, 30, 2, got);
      total += got;
      run_frame(3, 2, 2, got);
      total += got;

      while (total < 1650) begin
         if (total < 550) begin
            send_idle_pct = 35;
            recv_stall_pct = 86;
         end else if (total < 1100) begin
            send_idle_pct = 86;
            recv_stall_pct = 35;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         if ($urandom_range(0, 7) == 0)
            run_frame($urandom_range(13, 40), $urandom_range(1, 4), $urandom_range(0, 3), got);
         else
            run_frame($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 3), got);
         total += got;
      end
      wait_idle();

      if (fail_count == 0)
         $display("PASS median_filter_clipped_top");
      else
         $display("FAIL median_filter_clipped_top");
      $finish;
   end

endmodule
